// ===== rtl/yrgb_pkg.sv =====
// Shared constants and types for the YUYV to RGB888 converter.
package yrgb_pkg;

    // Width of the signed intermediate sums; the worst case needs 21 bits.
    localparam int SumWidth = 22;

    // Products, per-channel sums, luma and chroma offsets.
    typedef logic signed [SumWidth-1:0] sum_t;
    typedef logic signed [9:0]          off_t;
    typedef logic [7:0]                 chan_t;

    // Conversion coefficients, scaled by one thousand.
    localparam logic signed [12:0] LUMA_GAIN    = 13'sd1164;
    localparam logic signed [12:0] RED_V_GAIN   = 13'sd1159;
    localparam logic signed [12:0] GREEN_U_GAIN = 13'sd380;
    localparam logic signed [12:0] GREEN_V_GAIN = 13'sd813;
    localparam logic signed [12:0] BLUE_U_GAIN  = 13'sd2018;
    localparam off_t               LUMA_OFFSET   = 10'sd16;
    localparam off_t               CHROMA_OFFSET = 10'sd128;

    // Sums at or above this value saturate to full scale.
    localparam sum_t SAT_LIMIT = 22'sd256000;
    localparam chan_t CHAN_MAX = 8'd255;

    // Division by 1000 for sums below 256000: multiply by round-up(2^28/1000)
    // and keep bits 35..28. The error stays below 0.001 over that range, so
    // the quotient is exact.
    localparam int              QuotWidth  = 18;
    localparam int              RecipShift = 28;
    localparam logic [18:0]     RECIP_1000 = 19'd268436;

endpackage

// ===== rtl/yrgb_clamp_div.sv =====
// One output channel: divides a signed sum by 1000 and clamps it to 0..255.
module yrgb_clamp_div
    import yrgb_pkg::*;
(
    input  logic  aclk,
    input  logic  load_div,
    input  logic  load_out,
    input  sum_t  sum,
    output chan_t chan
);

    logic                 neg_reg, neg_next;
    logic                 sat_reg, sat_next;
    chan_t                quot_reg, quot_next;
    chan_t                chan_reg, chan_next;
    logic [QuotWidth-1:0] sum_low;
    logic [36:0]          recip_prod;

    // Range flags and the reciprocal multiplication for the quotient.
    always_comb begin
        neg_next   = sum[SumWidth-1];
        sat_next   = !sum[SumWidth-1] && (sum >= SAT_LIMIT);
        sum_low    = sum[QuotWidth-1:0];
        recip_prod = 37'(sum_low) * 37'(RECIP_1000);
        quot_next  = recip_prod[RecipShift+7:RecipShift];
    end

    // Final selection between zero, full scale and the quotient.
    always_comb begin
        if (neg_reg) begin
            chan_next = '0;
        end else if (sat_reg) begin
            chan_next = CHAN_MAX;
        end else begin
            chan_next = quot_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_div) begin
            neg_reg  <= neg_next;
            sat_reg  <= sat_next;
            quot_reg <= quot_next;
        end
        if (load_out) begin
            chan_reg <= chan_next;
        end
    end

    assign chan = chan_reg;

endmodule

// ===== rtl/yuyv_to_rgb888_converter_top.sv =====
// Top level of the YUYV macro-pixel to two RGB888 pixels converter.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+---------------------------------------
//  s_      | in        | s_valid / s_ready  | luma_first, chroma_blue, luma_second,
//          |           |                    | chroma_red (8 bits each)
//  m_      | out       | m_valid / m_ready  | red/green/blue of first and second
//          |           |                    | pixel (8 bits each)
//
// Four register stages: coefficient products, channel sums, division by 1000
// with range flags, and the clamped output register. One beat is accepted per
// cycle while s_ready is high; each beat moves through the stages in order, and
// m_valid rises once it reaches the output register.
// Each stage moves on when it is empty or the stage after it moves, so bubbles
// collapse and a stall on m_ready holds every beat in place.
// Reset (aresetn low, synchronous) clears the stage valid bits only.
module yuyv_to_rgb888_converter_top
    import yrgb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_luma_first,
    input  logic [7:0] s_chroma_blue,
    input  logic [7:0] s_luma_second,
    input  logic [7:0] s_chroma_red,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_red_first,
    output logic [7:0] m_green_first,
    output logic [7:0] m_blue_first,
    output logic [7:0] m_red_second,
    output logic [7:0] m_green_second,
    output logic [7:0] m_blue_second
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    off_t y0_off, y1_off, u_off, v_off;

    sum_t luma0_reg, luma1_reg, red_t_reg, gu_t_reg, gv_t_reg, blue_t_reg;
    sum_t luma0_next, luma1_next, red_t_next, gu_t_next, gv_t_next, blue_t_next;

    sum_t r0_reg, g0_reg, b0_reg, r1_reg, g1_reg, b1_reg;
    sum_t r0_next, g0_next, b0_next, r1_next, g1_next, b1_next;

    // Stage enables: a stage loads when it is empty or its successor loads.
    assign en4     = !v4_reg || m_ready;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;
    assign m_valid = v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // Stage one: remove the offsets and form the coefficient products.
    always_comb begin
        y0_off      = $signed({2'b00, s_luma_first})  - LUMA_OFFSET;
        y1_off      = $signed({2'b00, s_luma_second}) - LUMA_OFFSET;
        u_off       = $signed({2'b00, s_chroma_blue}) - CHROMA_OFFSET;
        v_off       = $signed({2'b00, s_chroma_red})  - CHROMA_OFFSET;
        luma0_next  = sum_t'(y0_off) * sum_t'(LUMA_GAIN);
        luma1_next  = sum_t'(y1_off) * sum_t'(LUMA_GAIN);
        red_t_next  = sum_t'(v_off) * sum_t'(RED_V_GAIN);
        gu_t_next   = sum_t'(u_off) * sum_t'(GREEN_U_GAIN);
        gv_t_next   = sum_t'(v_off) * sum_t'(GREEN_V_GAIN);
        blue_t_next = sum_t'(u_off) * sum_t'(BLUE_U_GAIN);
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            luma0_reg  <= luma0_next;
            luma1_reg  <= luma1_next;
            red_t_reg  <= red_t_next;
            gu_t_reg   <= gu_t_next;
            gv_t_reg   <= gv_t_next;
            blue_t_reg <= blue_t_next;
        end
    end

    // Stage two: combine luma and chroma terms into one sum per channel.
    always_comb begin
        r0_next = luma0_reg + red_t_reg;
        g0_next = luma0_reg - gu_t_reg - gv_t_reg;
        b0_next = luma0_reg + blue_t_reg;
        r1_next = luma1_reg + red_t_reg;
        g1_next = luma1_reg - gu_t_reg - gv_t_reg;
        b1_next = luma1_reg + blue_t_reg;
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            r0_reg <= r0_next;
            g0_reg <= g0_next;
            b0_reg <= b0_next;
            r1_reg <= r1_next;
            g1_reg <= g1_next;
            b1_reg <= b1_next;
        end
    end

    // Stages three and four: divide by 1000 and clamp, one unit per channel.
    yrgb_clamp_div u_red_first (
        .aclk(aclk), .load_div(en3), .load_out(en4), .sum(r0_reg), .chan(m_red_first)
    );
    yrgb_clamp_div u_green_first (
        .aclk(aclk), .load_div(en3), .load_out(en4), .sum(g0_reg), .chan(m_green_first)
    );
    yrgb_clamp_div u_blue_first (
        .aclk(aclk), .load_div(en3), .load_out(en4), .sum(b0_reg), .chan(m_blue_first)
    );
    yrgb_clamp_div u_red_second (
        .aclk(aclk), .load_div(en3), .load_out(en4), .sum(r1_reg), .chan(m_red_second)
    );
    yrgb_clamp_div u_green_second (
        .aclk(aclk), .load_div(en3), .load_out(en4), .sum(g1_reg), .chan(m_green_second)
    );
    yrgb_clamp_div u_blue_second (
        .aclk(aclk), .load_div(en3), .load_out(en4), .sum(b1_reg), .chan(m_blue_second)
    );

endmodule

// ===== tb/yrgb_checker.sv =====
// Checker for the YUYV to RGB888 converter: predicts each pixel pair and compares result beats.
module yrgb_checker
    import yrgb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  chan_t       s_luma_first,
    input  chan_t       s_chroma_blue,
    input  chan_t       s_luma_second,
    input  chan_t       s_chroma_red,
    input  logic        m_valid,
    input  logic        m_ready,
    input  chan_t       m_red_first,
    input  chan_t       m_green_first,
    input  chan_t       m_blue_first,
    input  chan_t       m_red_second,
    input  chan_t       m_green_second,
    input  chan_t       m_blue_second,
    output int          fail_count,
    output int unsigned pending_pairs
);
    timeunit 1ns;
    timeprecision 1ps;

    // Conversion coefficients, scaled by one thousand.
    localparam int YGain      = 1164;
    localparam int VToRed     = 1159;
    localparam int UToGreen   = 380;
    localparam int VToGreen   = 813;
    localparam int UToBlue    = 2018;
    localparam int Scale      = 1000;
    localparam int BlackLevel = 16;
    localparam int ChromaZero = 128;
    localparam int FullScale  = 255;

    typedef struct packed {
        chan_t red_first;
        chan_t green_first;
        chan_t blue_first;
        chan_t red_second;
        chan_t green_second;
        chan_t blue_second;
    } rgb_pair_t;

    rgb_pair_t expected_pixels[$];

    initial begin
        fail_count    = 0;
        pending_pairs = 0;
    end

    // Scale a signed channel sum down and saturate it to one byte.
    function automatic chan_t saturate_channel(input int sum);
        int quotient;
        if (sum < 0) begin
            return '0;
        end
        quotient = sum / Scale;
        if (quotient > FullScale) begin
            quotient = FullScale;
        end
        return chan_t'(quotient);
    endfunction

    // Both pixels of the macro-pixel share one set of chroma terms.
    function automatic rgb_pair_t convert_macro_pixel(input chan_t y0, input chan_t u,
                                                      input chan_t y1, input chan_t v);
        int        u_off;
        int        v_off;
        int        luma0;
        int        luma1;
        rgb_pair_t pair;
        u_off = int'(u) - ChromaZero;
        v_off = int'(v) - ChromaZero;
        luma0 = YGain * (int'(y0) - BlackLevel);
        luma1 = YGain * (int'(y1) - BlackLevel);
        pair.red_first    = saturate_channel(luma0 + VToRed * v_off);
        pair.green_first  = saturate_channel(luma0 - (UToGreen * u_off + VToGreen * v_off));
        pair.blue_first   = saturate_channel(luma0 + UToBlue * u_off);
        pair.red_second   = saturate_channel(luma1 + VToRed * v_off);
        pair.green_second = saturate_channel(luma1 - (UToGreen * u_off + VToGreen * v_off));
        pair.blue_second  = saturate_channel(luma1 + UToBlue * u_off);
        return pair;
    endfunction

    task automatic compare_channel(input string field, input chan_t expected,
                                   input chan_t actual);
        if (expected !== actual) begin
            $error("%s: expected %0d, actual %0d", field, expected, actual);
            fail_count++;
        end
    endtask

    // Compare each result beat with the oldest prediction, then record new input beats.
    always @(posedge aclk) begin
        rgb_pair_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("result beat arrived with no conversion pending");
                    fail_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    compare_channel("red_first",    want.red_first,    m_red_first);
                    compare_channel("green_first",  want.green_first,  m_green_first);
                    compare_channel("blue_first",   want.blue_first,   m_blue_first);
                    compare_channel("red_second",   want.red_second,   m_red_second);
                    compare_channel("green_second", want.green_second, m_green_second);
                    compare_channel("blue_second",  want.blue_second,  m_blue_second);
                end
            end
            if (s_valid && s_ready) begin
                expected_pixels.push_back(convert_macro_pixel(s_luma_first, s_chroma_blue,
                                                              s_luma_second, s_chroma_red));
            end
        end
        pending_pairs <= expected_pixels.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// Top of the converter testbench: clock, reset, beat stimulus and the final verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import yrgb_pkg::*;

    localparam int RandomBeats = 1000;
    localparam int Phases      = 3;
    localparam int DrainCycles = 8;
    localparam int CycleLimit  = 200000;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic m_ready = 1'b0;
    chan_t s_luma_first  = '0;
    chan_t s_chroma_blue = '0;
    chan_t s_luma_second = '0;
    chan_t s_chroma_red  = '0;
    logic  s_ready;
    logic  m_valid;
    chan_t m_red_first;
    chan_t m_green_first;
    chan_t m_blue_first;
    chan_t m_red_second;
    chan_t m_green_second;
    chan_t m_blue_second;

    int          fail_count;
    int unsigned pending_pairs;
    int unsigned cycle_count       = 0;
    int unsigned sender_idle_pct   = 24;
    int unsigned receiver_idle_pct = 64;

    // Directed macro-pixels, packed as Y0 U Y1 V.
    logic [31:0] directed_pairs[] = '{
        32'h00000000, 32'hFFFFFFFF, 32'h1080EB80, 32'hEB801080,
        32'h00FF00FF, 32'hFF00FF00, 32'hFF0000FF, 32'h00FFFF00,
        32'h10F0EB10, 32'hEB1010F0, 32'h80808080, 32'hAA55AA55,
        32'h55AA55AA, 32'h515A51F0, 32'hFF800080, 32'h0F801080,
        32'hEC80FE80, 32'h29F06E10, 32'hD2109210, 32'h10101010,
        32'hEBF0EBF0
    };

    always #5 aclk = ~aclk;

    yuyv_to_rgb888_converter_top u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_luma_first  (s_luma_first),
        .s_chroma_blue (s_chroma_blue),
        .s_luma_second (s_luma_second),
        .s_chroma_red  (s_chroma_red),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red_first   (m_red_first),
        .m_green_first (m_green_first),
        .m_blue_first  (m_blue_first),
        .m_red_second  (m_red_second),
        .m_green_second(m_green_second),
        .m_blue_second (m_blue_second)
    );

    yrgb_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_luma_first  (s_luma_first),
        .s_chroma_blue (s_chroma_blue),
        .s_luma_second (s_luma_second),
        .s_chroma_red  (s_chroma_red),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red_first   (m_red_first),
        .m_green_first (m_green_first),
        .m_blue_first  (m_blue_first),
        .m_red_second  (m_red_second),
        .m_green_second(m_green_second),
        .m_blue_second (m_blue_second),
        .fail_count    (fail_count),
        .pending_pairs (pending_pairs)
    );

    // The receiver holds back ready at random, at the rate of the current phase.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Guard against a hung handshake.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("status: fail");
            $finish;
        end
    end

    // Mostly uniform bytes, with a share drawn from range limits and the chroma midpoint.
    function automatic chan_t pick_byte();
        if ($urandom_range(3) == 0) begin
            case ($urandom_range(5))
                0: return 8'd0;
                1: return 8'd255;
                2: return 8'd16;
                3: return 8'd235;
                4: return 8'd240;
                default: return 8'd128;
            endcase
        end
        return chan_t'($urandom_range(255));
    endfunction

    // Offer one beat after an optional random gap; valid stays high on return.
    task automatic send_pair(input chan_t y0, input chan_t u, input chan_t y1,
                             input chan_t v);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_luma_first  <= y0;
        s_chroma_blue <= u;
        s_luma_second <= y1;
        s_chroma_red  <= v;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Hold the sender off until every predicted pair has been seen.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_pairs != 0);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed beats: range limits, neutral chroma, clamping at both ends.
        foreach (directed_pairs[i]) begin
            send_pair(directed_pairs[i][31:24], directed_pairs[i][23:16],
                      directed_pairs[i][15:8], directed_pairs[i][7:0]);
        end
        wait_for_drain();

        // Random beats: slow receiver, then slow sender, then full rate.
        for (int phase = 0; phase < Phases; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct   = 24;
                    receiver_idle_pct = 64;
                end
                1: begin
                    sender_idle_pct   = 64;
                    receiver_idle_pct = 24;
                end
                default: begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < RandomBeats / Phases + 1; n++) begin
                send_pair(pick_byte(), pick_byte(), pick_byte(), pick_byte());
            end
            wait_for_drain();
        end

        repeat (DrainCycles) @(posedge aclk);
        if (fail_count == 0 && pending_pairs == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== yuyv_to_rgb888_converter_top.f =====
rtl/yrgb_pkg.sv
rtl/yrgb_clamp_div.sv
rtl/yuyv_to_rgb888_converter_top.sv
tb/yrgb_checker.sv
tb/tb_top.sv
